/* design/lotc_pkg.sv */
// Package for the long option token checker.
// Holds the channel payload types, the phase and failure codes, the status codes
// and the character class functions. It depends on nothing.
`default_nettype none

package lotc_pkg;

  localparam int unsigned MAX_ARG_LEN_DEFAULT = 255;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;

  typedef enum logic [2:0] {
    ST_NAME_ONLY  = 3'd0,
    ST_NAME_VALUE = 3'd1,
    ST_BAD_PREFIX = 3'd2,
    ST_BAD_NAME   = 3'd3,
    ST_BAD_VALUE  = 3'd4,
    ST_BAD_FORMAT = 3'd5,
    ST_TOO_LONG   = 3'd6
  } status_t;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_DASH   = 6'b000010,
    PH_OPTION = 6'b000100,
    PH_NAME   = 6'b001000,
    PH_VALUE  = 6'b010000,
    PH_FAILED = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    FK_NONE   = 2'd0,
    FK_PREFIX = 2'd1,
    FK_NAME   = 2'd2,
    FK_VALUE  = 2'd3
  } fail_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       is_last;
  } tok_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] name_length;
    logic [7:0] value_length;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    fail_kind_t failure_kind;
    logic [7:0] name_count;
    logic [7:0] value_count;
    logic       overflowed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:        PH_START,
    failure_kind: FK_NONE,
    name_count:   8'd0,
    value_count:  8'd0,
    overflowed:   1'b0
  };

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    is_printable = (c >= 8'h20) && (c <= 8'h7E);
  endfunction

endpackage

`default_nettype wire

/* design/lotc_step.sv */
// Next-state and result logic of the token checker for one character.
// Purely combinational; uses lotc_pkg.
`default_nettype none

module lotc_step #(
  parameter int unsigned MAX_ARG_LEN = lotc_pkg::MAX_ARG_LEN_DEFAULT
) (
  input  wire lotc_pkg::scan_state_t cur,
  input  wire lotc_pkg::tok_t        item,
  output lotc_pkg::scan_state_t      nxt,
  output lotc_pkg::res_t             result
);
  import lotc_pkg::*;

  localparam logic [7:0] COUNT_CAP = 8'((MAX_ARG_LEN < 255) ? MAX_ARG_LEN : 255);

  logic [7:0] c;
  logic       name_full;
  logic       value_full;

  assign c          = item.char_code;
  assign name_full  = (cur.name_count >= COUNT_CAP);
  assign value_full = (cur.value_count >= COUNT_CAP);

  always_comb begin
    nxt = cur;
    if (item.char_valid) begin
      unique case (cur.phase)
        PH_START: begin
          if (c == CH_DASH) begin
            nxt.phase = PH_DASH;
          end else begin
            nxt.phase        = PH_FAILED;
            nxt.failure_kind = FK_PREFIX;
          end
        end
        PH_DASH: begin
          if (c == CH_DASH) begin
            nxt.phase = PH_OPTION;
          end else begin
            nxt.phase        = PH_FAILED;
            nxt.failure_kind = FK_PREFIX;
          end
        end
        PH_OPTION: begin
          if (is_letter(c)) begin
            if (name_full) begin
              nxt.overflowed = 1'b1;
              nxt.phase      = PH_FAILED;
            end else begin
              nxt.name_count = cur.name_count + 8'd1;
              nxt.phase      = PH_NAME;
            end
          end else begin
            nxt.phase        = PH_FAILED;
            nxt.failure_kind = FK_NAME;
          end
        end
        PH_NAME: begin
          if (c == CH_DASH || c == CH_UNDER || is_letter(c) || is_digit(c)) begin
            if (name_full) begin
              nxt.overflowed = 1'b1;
              nxt.phase      = PH_FAILED;
            end else begin
              nxt.name_count = cur.name_count + 8'd1;
            end
          end else if (c == CH_EQUALS) begin
            nxt.phase = PH_VALUE;
          end else begin
            nxt.phase        = PH_FAILED;
            nxt.failure_kind = FK_NAME;
          end
        end
        PH_VALUE: begin
          if (is_printable(c)) begin
            if (value_full) begin
              nxt.overflowed = 1'b1;
              nxt.phase      = PH_FAILED;
            end else begin
              nxt.value_count = cur.value_count + 8'd1;
            end
          end else begin
            nxt.phase        = PH_FAILED;
            nxt.failure_kind = FK_VALUE;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // Status of the token as it stands after this character.
  always_comb begin
    result.status       = ST_BAD_FORMAT;
    result.name_length  = 8'd0;
    result.value_length = 8'd0;
    if (nxt.overflowed) begin
      result.status = ST_TOO_LONG;
    end else if (nxt.phase == PH_NAME) begin
      result.status      = ST_NAME_ONLY;
      result.name_length = nxt.name_count;
    end else if (nxt.phase == PH_VALUE) begin
      result.status       = ST_NAME_VALUE;
      result.name_length  = nxt.name_count;
      result.value_length = nxt.value_count;
    end else if (nxt.phase == PH_FAILED) begin
      unique case (nxt.failure_kind)
        FK_PREFIX: result.status = ST_BAD_PREFIX;
        FK_NAME:   result.status = ST_BAD_NAME;
        FK_VALUE:  result.status = ST_BAD_VALUE;
        default:   result.status = ST_BAD_FORMAT;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/long_option_token_checker.sv */
// Top level of the long option token checker: input register, scan state,
// result register. Uses lotc_pkg and lotc_step.
//
//   channel | direction | payload          | handshake
//   tok     | in        | lotc_pkg::tok_t  | tok_valid / tok_stall
//   res     | out       | lotc_pkg::res_t  | res_valid / res_stall
//
// One character per clock sustained while no result is held stalled; a token's result
// is offered after its last character passes the input and result registers.
// The scan state is updated from the input register, so the next character
// sees the updated state with no bubble.
// rst clears the scan state and both valid flags.
// A held result stalls the input only when the waiting character ends a token.
`default_nettype none

module long_option_token_checker #(
  parameter int unsigned MAX_ARG_LEN = lotc_pkg::MAX_ARG_LEN_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tok_valid,
  output logic                tok_stall,
  input  wire lotc_pkg::tok_t tok_data,
  output logic                res_valid,
  input  wire logic           res_stall,
  output lotc_pkg::res_t      res_data
);
  import lotc_pkg::*;

  tok_t        held;
  logic        held_valid;
  scan_state_t scan;
  scan_state_t scan_next;
  res_t        result_next;
  logic        res_free;
  logic        fire;

  lotc_step #(
    .MAX_ARG_LEN(MAX_ARG_LEN)
  ) u_step (
    .cur    (scan),
    .item   (held),
    .nxt    (scan_next),
    .result (result_next)
  );

  assign res_free  = !res_valid || !res_stall;
  assign fire      = held_valid && (!held.is_last || res_free);
  assign tok_stall = held_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (tok_valid && !tok_stall) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid && !tok_stall) begin
      held <= tok_data;
    end
  end

  // Return to the start phase after each token ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (fire) begin
      scan <= held.is_last ? SCAN_RESET : scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && held.is_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && held.is_last) begin
      res_data <= result_next;
    end
  end

endmodule

`default_nettype wire

/* design/lotc_checker.sv */
// Port-level checks for the long option token checker, bound to its top level.
// Uses lotc_pkg.
`default_nettype none

module lotc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           tok_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire lotc_pkg::res_t res_data
);
  import lotc_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("result changed while stalled");

  // The input only backs up behind a result that cannot leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    tok_stall |-> res_valid && res_stall)
    else $error("input stalled with the result side free");

  a_fail_lengths: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status >= ST_BAD_PREFIX
      |-> res_data.name_length == 8'd0 && res_data.value_length == 8'd0)
    else $error("failed token reports a length");

  a_name_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_NAME_ONLY
      |-> res_data.name_length != 8'd0 && res_data.value_length == 8'd0)
    else $error("name-only token with bad lengths");

endmodule

bind long_option_token_checker lotc_checker u_lotc_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_stall (tok_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

`default_nettype wire
